@@ rtl/core/tbo_pkg.sv @@
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared sizes, command codes, payload types and control structs for the
// one-shot / periodic timer bank.
// ----------------------------------------------------------------------------
package tbo_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MASK_W      = 16;
    localparam int SHOWN       = (SLOT_COUNT < MASK_W) ? SLOT_COUNT : MASK_W;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } tbo_cmd_code_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot;
        logic [31:0] target_ticks;
        logic        repeat_req;
    } tbo_in_t;

    typedef struct packed {
        logic [MASK_W-1:0] fired_mask;
        logic [MASK_W-1:0] active_mask;
    } tbo_out_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;     // capture the accepted item, restart the sweep
        logic step;      // one sweep step, or apply start/stop
        logic load_out;  // move the result into the output register
    } tbo_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic step_last; // this step finishes the item
    } tbo_stat_t;

endpackage

@@ rtl/core/tbo_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbo_ctrl
// Controller: accepts items, runs the slot sweep or the start/stop update,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module tbo_ctrl
    import tbo_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output tbo_ctrl_t ctrl,
    input  tbo_stat_t stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign s_ready  = s_ready_reg;
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        ctrl          = '0;
        ctrl.latch    = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
        ctrl.step     = (state_reg == ST_EXEC);
        ctrl.load_out = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        s_ready_reg <= 1'b0;
                        state_reg   <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (stat.step_last) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold until the previous result transfer has gone
                    if (out_free) begin
                        s_ready_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/tbo_dp.sv @@
// ----------------------------------------------------------------------------
// tbo_dp
// Datapath: slot flags, target and count stores, sweep index, fire
// accumulator and output register.
// ----------------------------------------------------------------------------
module tbo_dp
    import tbo_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  tbo_in_t   s_data,
    output tbo_out_t  m_data,
    input  tbo_ctrl_t ctrl,
    output tbo_stat_t stat
);

    tbo_in_t                 item_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [SLOT_COUNT-1:0]   active_reg;
    logic [SLOT_COUNT-1:0]   periodic_reg;
    logic [MASK_W-1:0]       fired_reg;
    tbo_out_t                out_reg;

    logic [COUNT_WIDTH-1:0]  target_mem [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0]  count_mem  [SLOT_COUNT];

    logic                    is_tick;
    logic                    is_start;
    logic                    is_stop;
    logic                    slot_ok;
    logic [IDX_W-1:0]        slot_idx;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic                    hit;
    logic                    sweep_last;
    logic                    cnt_we;
    logic [IDX_W-1:0]        cnt_addr;
    logic [COUNT_WIDTH-1:0]  cnt_wdata;
    logic [MASK_W-1:0]       active_shown;

    assign is_tick  = (item_reg.command == CMD_TICK);
    assign is_start = (item_reg.command == CMD_START);
    assign is_stop  = (item_reg.command == CMD_STOP);
    assign slot_ok  = (32'(item_reg.slot) < 32'(SLOT_COUNT));
    assign slot_idx = IDX_W'(item_reg.slot);

    assign count_inc  = count_mem[idx_reg] + COUNT_WIDTH'(1);
    assign hit        = active_reg[idx_reg] && (count_inc == target_mem[idx_reg]);
    assign sweep_last = (idx_reg == IDX_W'(SLOT_COUNT - 1));

    assign stat.step_last = !is_tick || sweep_last;

    // one write port on the count store: sweep write-back or clear on start
    always_comb begin
        cnt_we    = 1'b0;
        cnt_addr  = idx_reg;
        cnt_wdata = hit ? '0 : count_inc;
        if (ctrl.step) begin
            if (is_tick) begin
                cnt_we = 1'b1;
            end else if (is_start && slot_ok) begin
                cnt_we    = 1'b1;
                cnt_addr  = slot_idx;
                cnt_wdata = '0;
            end
        end
    end

    always_comb begin
        active_shown = '0;
        for (int j = 0; j < SHOWN; j++) begin
            active_shown[j] = active_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            count_mem[cnt_addr] <= cnt_wdata;
        end
        if (ctrl.step && is_start && slot_ok) begin
            target_mem[slot_idx] <= COUNT_WIDTH'(item_reg.target_ticks);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.latch) begin
            item_reg <= s_data;
        end
        if (ctrl.load_out) begin
            out_reg.fired_mask  <= fired_reg;
            out_reg.active_mask <= active_shown;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            active_reg   <= '0;
            periodic_reg <= '0;
            fired_reg    <= '0;
        end else begin
            if (ctrl.latch) begin
                idx_reg   <= '0;
                fired_reg <= '0;
            end else if (ctrl.step) begin
                if (is_tick) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (hit) begin
                        if (!periodic_reg[idx_reg]) begin
                            active_reg[idx_reg] <= 1'b0;
                        end
                        for (int j = 0; j < SHOWN; j++) begin
                            if (32'(idx_reg) == j) begin
                                fired_reg[j] <= 1'b1;
                            end
                        end
                    end
                end else if (is_start && slot_ok) begin
                    active_reg[slot_idx]   <= 1'b1;
                    periodic_reg[slot_idx] <= item_reg.repeat_req;
                end else if (is_stop && slot_ok) begin
                    active_reg[slot_idx] <= 1'b0;
                end
            end
        end
    end

    assign m_data = out_reg;

endmodule

@@ rtl/core/timer_bank_oneshot_periodic_top.sv @@
// ----------------------------------------------------------------------------
// timer_bank_oneshot_periodic_top
// A tick sweeps the slots in ST_EXEC, one sweep step per slot, then ST_DONE loads
// the output register and raises m_valid. Start, stop and unused commands take a
// single step in ST_EXEC before ST_DONE.
// Items are taken one at a time: s_ready returns in the same cycle that the result
// loads, and ST_DONE waits while a previous result is still stalled on the output.
// Reset (aresetn, synchronous, active low) disarms every slot and empties the output.
// ----------------------------------------------------------------------------
module timer_bank_oneshot_periodic_top
    import tbo_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tbo_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tbo_out_t m_data
);

    tbo_ctrl_t ctrl;
    tbo_stat_t stat;

    tbo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    tbo_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .ctrl    (ctrl),
        .stat    (stat)
    );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the one-shot / periodic timer bank. A short table of
// directed commands is followed by random start, stop, tick and unused
// traffic. Each result is checked against the table or a cycle-free model
// of the slot bank, with random input gaps and random result-side stalls.
// ----------------------------------------------------------------------------
module testbench;
    import tbo_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam logic       CHECK          = 1'b1;
    localparam logic       PREDICT        = 1'b0;
    localparam int         RANDOM_ITEMS   = 700;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         DRAIN_CYCLES   = 4 * (SLOT_COUNT + 2);

    typedef struct packed {
        tbo_in_t  item;
        logic     typed;
        tbo_out_t want;
    } stim_row_t;

    // command, slot, target, periodic, typed check, fired mask, active mask
    localparam stim_row_t DIRECTED_ROWS [0:25] = '{
        {CMD_TICK,   4'd15, 32'hFFFF_FFFF, 1'b1, CHECK,   16'h0000, 16'h0000},
        {CMD_STOP,   4'd5,  32'h0000_0000, 1'b0, CHECK,   16'h0000, 16'h0000},
        {CMD_UNUSED, 4'd15, 32'hFFFF_FFFF, 1'b1, CHECK,   16'h0000, 16'h0000},
        {CMD_START,  4'd0,  32'h0000_0001, 1'b1, CHECK,   16'h0000, 16'h0001},
        {CMD_START,  4'd15, 32'hFFFF_FFFF, 1'b0, CHECK,   16'h0000, 16'h8001},
        {CMD_START,  4'd7,  32'h0000_0000, 1'b1, CHECK,   16'h0000, 16'h8081},
        {CMD_TICK,   4'd0,  32'h0000_0000, 1'b0, CHECK,   16'h0001, 16'h8081},
        {CMD_START,  4'd3,  32'h0000_0002, 1'b0, CHECK,   16'h0000, 16'h8089},
        {CMD_TICK,   4'd0,  32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_TICK,   4'd9,  32'h5A5A_A5A5, 1'b1, PREDICT, 16'h0000, 16'h0000},
        {CMD_START,  4'd1,  32'h0000_0001, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_START,  4'd2,  32'h0000_0001, 1'b1, PREDICT, 16'h0000, 16'h0000},
        {CMD_TICK,   4'd0,  32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_UNUSED, 4'd2,  32'h0000_0003, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_START,  4'd2,  32'h0000_0003, 1'b1, PREDICT, 16'h0000, 16'h0000},
        {CMD_TICK,   4'd0,  32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_TICK,   4'd0,  32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_TICK,   4'd0,  32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_STOP,   4'd0,  32'hFFFF_FFFF, 1'b1, PREDICT, 16'h0000, 16'h0000},
        {CMD_STOP,   4'd0,  32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_TICK,   4'd0,  32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_START,  4'd0,  32'h0000_0002, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_TICK,   4'd0,  32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_TICK,   4'd0,  32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_STOP,   4'd15, 32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000},
        {CMD_STOP,   4'd7,  32'h0000_0000, 1'b0, PREDICT, 16'h0000, 16'h0000}
    };

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tbo_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tbo_out_t m_data;

    // model of the slot bank
    logic                   slot_armed_q  [SLOT_COUNT];
    logic                   slot_repeat_q [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0] slot_target_q [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0] slot_ticks_q  [SLOT_COUNT];

    tbo_out_t expected_masks [$];
    tbo_out_t oldest_masks;
    int       error_count = 0;
    int       idle_cycles = 0;
    bit       burst_mode  = 1'b0;

    timer_bank_oneshot_periodic_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    function automatic tbo_out_t advance_timers(input tbo_in_t item);
        tbo_out_t res;
        res = '0;
        case (item.command)
            CMD_TICK: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    slot_ticks_q[i] = slot_ticks_q[i] + 1'b1;
                    if (slot_armed_q[i] && slot_ticks_q[i] == slot_target_q[i]) begin
                        slot_ticks_q[i] = '0;
                        if (i < MASK_W) res.fired_mask[i] = 1'b1;
                        if (!slot_repeat_q[i]) slot_armed_q[i] = 1'b0;
                    end
                end
            end
            CMD_START: begin
                if (item.slot < SLOT_COUNT) begin
                    slot_armed_q[item.slot]  = 1'b1;
                    slot_repeat_q[item.slot] = item.repeat_req;
                    slot_target_q[item.slot] = COUNT_WIDTH'(item.target_ticks);
                    slot_ticks_q[item.slot]  = '0;
                end
            end
            CMD_STOP: begin
                if (item.slot < SLOT_COUNT) slot_armed_q[item.slot] = 1'b0;
            end
            default: ;
        endcase
        for (int i = 0; i < SHOWN; i++) res.active_mask[i] = slot_armed_q[i];
        return res;
    endfunction

    function automatic tbo_in_t random_command();
        tbo_in_t item;
        int pick;
        item.slot         = 4'($urandom_range(0, 15));
        item.target_ticks = $urandom;
        item.repeat_req   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            item.command = CMD_TICK;
        end else if (pick < 80) begin
            item.command = CMD_START;
            // keep most targets short so slots actually fire
            pick = $urandom_range(0, 9);
            if (pick == 0) item.target_ticks = '0;
            else if (pick < 9) item.target_ticks = 32'($urandom_range(1, 6));
        end else if (pick < 96) begin
            item.command = CMD_STOP;
        end else begin
            item.command = CMD_UNUSED;
        end
        return item;
    endfunction

    task automatic send_item(input tbo_in_t item, input logic typed, input tbo_out_t want);
        int gap;
        tbo_out_t predicted;
        gap = burst_mode ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = advance_timers(item);
        expected_masks = {expected_masks, (typed ? want : predicted)};
        @(negedge aclk);
    endtask

    // result side: draw a stall for every transfer
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_masks.size() == 0) begin
                report_mismatch($sformatf("result %h with no transfer pending", m_data));
            end else begin
                oldest_masks = expected_masks.pop_front();
                if (m_data.fired_mask !== oldest_masks.fired_mask)
                    report_mismatch($sformatf("fired_mask got %h expected %h",
                                              m_data.fired_mask, oldest_masks.fired_mask));
                if (m_data.active_mask !== oldest_masks.active_mask)
                    report_mismatch($sformatf("active_mask got %h expected %h",
                                              m_data.active_mask, oldest_masks.active_mask));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        tbo_in_t item;
        int sent;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_armed_q[i]  = 1'b0;
            slot_repeat_q[i] = 1'b0;
            slot_target_q[i] = '0;
            slot_ticks_q[i]  = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r <= 25; r++)
            send_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // hold the sender until the bank has drained
        s_valid <= 1'b0;
        wait (expected_masks.size() == 0);
        @(negedge aclk);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            if (sent == RANDOM_ITEMS / 2) begin
                s_valid <= 1'b0;
                wait (expected_masks.size() == 0);
                @(negedge aclk);
            end
            item = random_command();
            send_item(item, PREDICT, '0);
            if (item.command != CMD_UNUSED) sent++;
        end
        s_valid <= 1'b0;

        wait (expected_masks.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_masks.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_masks.size()));
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tbo_pkg.sv
rtl/core/tbo_ctrl.sv
rtl/core/tbo_dp.sv
rtl/core/timer_bank_oneshot_periodic_top.sv
sim/testbench.sv
